@@ design/gmis_pkg.sv @@
`default_nettype none
package gmis_pkg;

	localparam int SEG_W     = 9;
	localparam int IDX_W     = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_MODE = 2'd1;

	// strip mode phases
	localparam logic [2:0] PH_BEGIN = 3'd0;
	localparam logic [2:0] PH_NEXT  = 3'd1;
	localparam logic [2:0] PH_CUR   = 3'd2;
	localparam logic [2:0] PH_END   = 3'd3;

	// list mode corners of a quad: v, v+1, v+S, v+1, v+S+1, v+S
	localparam logic [2:0] LQ_TL  = 3'd0;
	localparam logic [2:0] LQ_TR  = 3'd1;
	localparam logic [2:0] LQ_BL  = 3'd2;
	localparam logic [2:0] LQ_TR2 = 3'd3;
	localparam logic [2:0] LQ_BR  = 3'd4;
	localparam logic [2:0] LQ_BL2 = 3'd5;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic             strip_mode;
		logic             write;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic             last;
		logic             done_res;
	} result_t;

endpackage
`default_nettype wire

@@ design/grid_mesh_index_sequencer.sv @@
`default_nettype none
// Grid mesh index sequencer: streams the vertex index list of a square grid.
// Input channel (in_valid / in_stall / restart): every accepted item asks for
//   one index; restart = 1 starts the list over and returns its first index.
// Output channel (out_valid / out_stall / vertex_index, last, done_res): one
//   result item per input item, in order. last marks the final index of the
//   list; done_res = 1 (index 0) answers a request after the list has ended.
// Config port (cfg_we / cfg_index / cfg_data): segments (index 0, clamped to
//   2..MAX_SEGMENTS) and strip_mode (index 1). A write to either ends the
//   running list. Write only while no item is in flight.
// Timing: an accepted item is held in the input register, and its result is
//   registered in the output register. One item per cycle is sustained while
//   out_stall is low; the state loop (row, column, phase, base) uses adders only.
// Stall: the input register keeps taking an item while the output register
//   holds a stalled result; in_stall rises only when both are occupied.
// Reset: both stages empty, segments = 2, strip_mode = 1, and requests answer
//   done until the first restart.
module grid_mesh_index_sequencer #(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [gmis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [gmis_pkg::SEG_W-1:0]      cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            restart,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [gmis_pkg::IDX_W-1:0]     vertex_index,
	output logic                           last,
	output logic                           done_res
);
	import gmis_pkg::*;

	// row and column counters only need to reach MAX_SEGMENTS-1
	localparam int CW = $clog2(MAX_SEGMENTS);

	cfg_t    cfg;
	result_t step_res, out_res;
	logic    valid_s1, restart_s1;
	logic    advance, step_en, finished, accept;

	gmis_cfg #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// input register
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			restart_s1 <= restart;
		end
	end

	// state advances exactly when the item moves into the output register
	assign step_en = valid_s1 && advance;

	gmis_core #(
		.CW(CW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (step_en),
		.restart (restart_s1),
		.res     (step_res),
		.finished(finished)
	);

	gmis_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_res   (step_res),
		.advance  (advance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign vertex_index = out_res.vertex_index;
	assign last         = out_res.last;
	assign done_res     = out_res.done_res;

	// a done answer never carries an index or a last mark
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> vertex_index == '0 && !last)
		else $error("done result carries index or last");

	// back-to-back steps need a fresh item accepted in between
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> !step_en || $past(accept))
		else $error("item stepped twice");

	// any register write ends the list
	a_cfg_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_SEGMENTS || cfg_index == REG_STRIP_MODE)
		|=> finished)
		else $error("list still running after config write");

	// a result marked last leaves the list finished
	a_last_fin: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && step_res.last && !cfg.write |=> finished)
		else $error("list not finished after last index");

endmodule
`default_nettype wire

@@ design/gmis_cfg.sv @@
`default_nettype none
module gmis_cfg #(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [gmis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [gmis_pkg::SEG_W-1:0]          cfg_data,
	output gmis_pkg::cfg_t                      cfg
);
	import gmis_pkg::*;

	localparam logic [SEG_W-1:0] SEG_MIN = SEG_W'(2);
	localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

	logic [SEG_W-1:0] seg_q;
	logic             strip_q;
	logic [SEG_W-1:0] seg_clamped;

	always_comb begin
		priority if (cfg_data < SEG_MIN) begin
			seg_clamped = SEG_MIN;
		end else if (cfg_data > SEG_MAX) begin
			seg_clamped = SEG_MAX;
		end else begin
			seg_clamped = cfg_data;
		end
	end

	// segments is held already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_MIN;
			strip_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_SEGMENTS) begin
				seg_q <= seg_clamped;
			end
			if (cfg_index == REG_STRIP_MODE) begin
				strip_q <= cfg_data[0];
			end
		end
	end

	assign cfg.segments   = seg_q;
	assign cfg.strip_mode = strip_q;
	assign cfg.write      = cfg_we &&
		(cfg_index == REG_SEGMENTS || cfg_index == REG_STRIP_MODE);

endmodule
`default_nettype wire

@@ design/gmis_core.sv @@
`default_nettype none
module gmis_core #(
	parameter int CW = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gmis_pkg::cfg_t      cfg,
	input  wire                 step_en,
	input  wire                 restart,
	output gmis_pkg::result_t   res,
	output logic                finished
);
	import gmis_pkg::*;

	logic [CW-1:0]    row_q, col_q;
	logic [2:0]       phase_q;
	logic [IDX_W-1:0] base_q;   // row_q * segments, kept by adding
	logic             fin_q;

	logic [CW-1:0]    r, c, r_nx, c_nx;
	logic [2:0]       ph, ph_nx;
	logic [IDX_W-1:0] base, base_nx, s16, c16, v;
	logic             fin, fin_nx, is_last;
	logic             row_end, col_end_strip, col_end_list;

	always_comb begin
		// restart overrides the state before the step
		if (restart) begin
			r    = '0;
			c    = '0;
			ph   = cfg.strip_mode ? PH_NEXT : LQ_TL;
			base = '0;
			fin  = 1'b0;
		end else begin
			r    = row_q;
			c    = col_q;
			ph   = phase_q;
			base = base_q;
			fin  = fin_q;
		end

		s16           = IDX_W'(cfg.segments);
		c16           = IDX_W'(c);
		row_end       = SEG_W'(r) >= cfg.segments - SEG_W'(2);
		col_end_strip = SEG_W'(c) >= cfg.segments - SEG_W'(1);
		col_end_list  = SEG_W'(c) >= cfg.segments - SEG_W'(2);

		r_nx    = r;
		c_nx    = c;
		ph_nx   = ph;
		base_nx = base;
		fin_nx  = fin;
		is_last = 1'b0;
		v       = '0;

		if (fin) begin
			v = '0;
		end else if (cfg.strip_mode) begin
			unique case (ph)
				PH_BEGIN: begin
					v     = base + s16;
					c_nx  = '0;
					ph_nx = PH_NEXT;
				end
				PH_CUR: begin
					v = base + c16;
					if (col_end_strip) begin
						ph_nx = PH_END;
					end else begin
						c_nx  = c + CW'(1);
						ph_nx = PH_NEXT;
					end
				end
				PH_END: begin
					v = base + s16 - IDX_W'(1);
					if (row_end) begin
						is_last = 1'b1;
						fin_nx  = 1'b1;
					end else begin
						r_nx    = r + CW'(1);
						c_nx    = '0;
						base_nx = base + s16;
						ph_nx   = PH_BEGIN;
					end
				end
				default: begin
					v     = base + s16 + c16;
					ph_nx = PH_CUR;
				end
			endcase
		end else begin
			unique case (ph)
				LQ_TL:   v = base + c16;
				LQ_TR:   v = base + c16 + IDX_W'(1);
				LQ_BL:   v = base + c16 + s16;
				LQ_TR2:  v = base + c16 + IDX_W'(1);
				LQ_BR:   v = base + c16 + s16 + IDX_W'(1);
				default: v = base + c16 + s16;
			endcase
			if (ph < LQ_BL2) begin
				ph_nx = ph + 3'd1;
			end else begin
				ph_nx = LQ_TL;
				if (col_end_list) begin
					if (row_end) begin
						is_last = 1'b1;
						fin_nx  = 1'b1;
					end else begin
						r_nx    = r + CW'(1);
						c_nx    = '0;
						base_nx = base + s16;
					end
				end else begin
					c_nx = c + CW'(1);
				end
			end
		end

		res.vertex_index = v;
		res.last         = is_last;
		res.done_res     = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			phase_q <= '0;
			base_q  <= '0;
			fin_q   <= 1'b1;
		end else if (cfg.write) begin
			fin_q <= 1'b1;
		end else if (step_en) begin
			row_q   <= r_nx;
			col_q   <= c_nx;
			phase_q <= ph_nx;
			base_q  <= base_nx;
			fin_q   <= fin_nx;
		end
	end

	assign finished = fin_q;

endmodule
`default_nettype wire

@@ design/gmis_out_reg.sv @@
`default_nettype none
module gmis_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  gmis_pkg::result_t   in_res,
	output logic                advance,
	output logic                out_valid,
	input  wire                 out_stall,
	output gmis_pkg::result_t   out_res
);
	import gmis_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			res_q <= in_res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

@@ bench/grid_mesh_index_sequencer_tb.sv @@
`timescale 1ns / 1ps

module grid_mesh_index_sequencer_tb;
	import gmis_pkg::*;

	localparam int MAX_SEG = 256;
	// no-activity cycles before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// about this many random requests after the directed part
	localparam int RANDOM_ITEMS = 1600;
	// indexes the block does not decode; a write there must leave the list running
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SEG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 restart = 1'b0;
	logic                 out_stall = 1'b0;
	wire                  in_stall;
	wire                  out_valid;
	wire  [IDX_W-1:0]     vertex_index;
	wire                  last;
	wire                  done_res;

	grid_mesh_index_sequencer #(
		.MAX_SEGMENTS(MAX_SEG)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_index (vertex_index),
		.last         (last),
		.done_res     (done_res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Index walk mirror: register copy plus row / column / phase state.
	// Advanced once per accepted request, in acceptance order.
	// ------------------------------------------------------------------
	logic [SEG_W-1:0] cfg_segments = 9'd2;
	logic             cfg_strip = 1'b1;
	logic [7:0]       grid_row = '0;
	logic [8:0]       grid_col = '0;
	logic [2:0]       walk_phase = '0;
	logic             list_done = 1'b1;   // done until the first restart

	result_t expected_index_q[$];
	bit      pending_restart[$];

	int  items_out = 0;       // queued but not yet answered
	int  items_queued = 0;
	int  results_seen = 0;
	int  lists_closed = 0;
	int  done_answers = 0;
	int  mismatch_cnt = 0;
	int  quiet_cycles = 0;
	int  run_no = 0;
	bit  steady = 1'b0;       // no idling on either side while set

	function automatic int unsigned grid_edge();
		if (cfg_segments < 2)
			return 2;
		if (cfg_segments > MAX_SEG)
			return MAX_SEG;
		return cfg_segments;
	endfunction

	function automatic result_t next_grid_index(input logic rst);
		result_t     r;
		int unsigned s;
		int unsigned v;
		int unsigned base;
		s = grid_edge();
		r = '0;
		if (rst) begin
			grid_row = '0;
			grid_col = '0;
			walk_phase = cfg_strip ? PH_NEXT : LQ_TL;
			list_done = 1'b0;
		end
		if (list_done) begin
			r.done_res = 1'b1;
			return r;
		end
		if (cfg_strip) begin
			case (walk_phase)
				PH_BEGIN: begin
					// degenerate opener: first vertex of the next row
					v = (grid_row + 1) * s;
					grid_col = '0;
					walk_phase = PH_NEXT;
				end
				PH_CUR: begin
					v = grid_row * s + grid_col;
					if (grid_col >= s - 1) begin
						walk_phase = PH_END;
					end else begin
						grid_col = grid_col + 9'd1;
						walk_phase = PH_NEXT;
					end
				end
				PH_END: begin
					// degenerate closer: last vertex of the current row
					v = grid_row * s + (s - 1);
					if (grid_row >= s - 2) begin
						r.last = 1'b1;
						list_done = 1'b1;
					end else begin
						grid_row = grid_row + 8'd1;
						grid_col = '0;
						walk_phase = PH_BEGIN;
					end
				end
				default: begin
					v = (grid_row + 1) * s + grid_col;
					walk_phase = PH_CUR;
				end
			endcase
		end else begin
			base = grid_row * s + grid_col;
			case (walk_phase)
				LQ_TL:         v = base;
				LQ_TR, LQ_TR2: v = base + 1;
				LQ_BL:         v = base + s;
				LQ_BR:         v = base + s + 1;
				default:       v = base + s;
			endcase
			if (walk_phase < LQ_BL2) begin
				walk_phase = walk_phase + 3'd1;
			end else begin
				walk_phase = LQ_TL;
				if (grid_col >= s - 2) begin
					if (grid_row >= s - 2) begin
						r.last = 1'b1;
						list_done = 1'b1;
					end else begin
						grid_row = grid_row + 8'd1;
						grid_col = '0;
					end
				end else begin
					grid_col = grid_col + 9'd1;
				end
			end
		end
		r.vertex_index = v[IDX_W-1:0];
		return r;
	endfunction

	function automatic bit roll_idle();
		return !steady && ($urandom_range(99) < 34);
	endfunction

	// ------------------------------------------------------------------
	// Request driver: holds the item while stalled, predicts on acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_index_q = {expected_index_q, next_grid_index(restart)};
			end
			if (!in_valid || !in_stall) begin
				if (pending_restart.size() != 0 && !roll_idle()) begin
					in_valid <= 1'b1;
					restart <= pending_restart.pop_front();
				end else begin
					in_valid <= 1'b0;
					restart <= 1'($urandom_range(1));   // junk while idle
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random backpressure, in-order compare
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.vertex_index = vertex_index;
				got.last = last;
				got.done_res = done_res;
				results_seen++;
				if (items_out > 0)
					items_out--;
				if (expected_index_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result %0d with nothing expected: index %0d last %0b done %0b",
							results_seen, got.vertex_index, got.last, got.done_res);
				end else begin
					want = expected_index_q.pop_front();
					if (want.last)
						lists_closed++;
					if (want.done_res)
						done_answers++;
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("result %0d mismatch: expected index %0d last %0b done %0b",
								results_seen, want.vertex_index, want.last, want.done_res);
							$display("  got index %0d last %0b done %0b",
								got.vertex_index, got.last, got.done_res);
						end
					end
				end
			end
			out_stall <= roll_idle();
		end
	end

	// hang detection: nothing moving on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d requests still unanswered", items_out);
			$display("grid_mesh_index_sequencer_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic ask(input bit rst);
		pending_restart = {pending_restart, rst};
		items_out++;
		items_queued++;
	endtask

	// wait for every answer, then let the pipe empty
	task automatic settle();
		wait (items_out == 0);
		repeat (3) @(posedge clk);
	endtask

	// only called while idle, so the mirror can take the write right away
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SEGMENTS: begin
				cfg_segments = data;
				list_done = 1'b1;
			end
			REG_STRIP_MODE: begin
				cfg_strip = data[0];
				list_done = 1'b1;
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned seg;
		int unsigned s;
		int unsigned len;
		int unsigned n;
		int          rand_start;
		bit          broken;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// -- directed --
		// requests before any restart answer done
		ask(1'b0);
		ask(1'b0);
		// smallest grid, strip: 5 indices then done
		ask(1'b1);
		repeat (4) ask(1'b0);
		ask(1'b0);
		settle();

		// smallest grid, list: one quad, then done
		write_reg(REG_STRIP_MODE, 9'd0);
		ask(1'b1);
		repeat (5) ask(1'b0);
		ask(1'b0);
		settle();

		// segments below range clamp to 2; undecoded index keeps the list alive
		write_reg(REG_SEGMENTS, 9'd0);
		write_reg(REG_STRIP_MODE, 9'd1);
		ask(1'b1);
		ask(1'b0);
		ask(1'b0);
		settle();
		write_reg(REG_UNUSED_HI, 9'h1ff);
		ask(1'b0);
		ask(1'b0);
		settle();

		// top of range clamps to MAX; restart mid-list; a real write ends the list
		write_reg(REG_SEGMENTS, 9'd511);
		ask(1'b1);
		ask(1'b0);
		ask(1'b0);
		ask(1'b1);
		ask(1'b0);
		settle();
		write_reg(REG_SEGMENTS, 9'd257);
		ask(1'b0);
		settle();

		// -- random runs: mostly complete lists on small grids --
		rand_start = items_queued;
		while (items_queued < rand_start + RANDOM_ITEMS) begin
			run_no++;
			steady = (run_no >= 6 && run_no <= 8);
			settle();

			if ($urandom_range(99) < 70) begin
				seg = $urandom_range(6, 2);
			end else if ($urandom_range(99) < 50) begin
				seg = $urandom_range(16, 7);
			end else begin
				case ($urandom_range(5))
					0: seg = 0;
					1: seg = 1;
					2: seg = 256;
					3: seg = 257;
					4: seg = 511;
					default: seg = $urandom_range(511, 17);
				endcase
			end
			if ($urandom_range(9) != 0)
				write_reg(REG_SEGMENTS, seg[SEG_W-1:0]);
			if ($urandom_range(9) != 0)
				write_reg(REG_STRIP_MODE, SEG_W'($urandom_range(511)));
			if ($urandom_range(9) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
					SEG_W'($urandom_range(511)));

			s = grid_edge();
			if (cfg_strip)
				len = (s - 1) * (2 * s + 1) + (s - 2);
			else
				len = 6 * (s - 1) * (s - 1);
			n = len + $urandom_range(3);
			// big grids never finish in budget; just walk into them
			if (n > 160)
				n = $urandom_range(160, 60);

			broken = ($urandom_range(99) < 20);
			for (int i = 0; i < n; i++) begin
				if (broken)
					ask($urandom_range(15) == 0);
				else
					ask(i == 0);
			end
		end
		settle();
		repeat (4) @(posedge clk);

		mismatch_cnt += expected_index_q.size();
		$display("%0d requests over %0d random runs plus directed cases", items_queued, run_no);
		$display("%0d results checked, %0d lists finished, %0d done answers, %0d mismatches",
			results_seen, lists_closed, done_answers, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("grid_mesh_index_sequencer_tb: clean");
		end else begin
			$display("grid_mesh_index_sequencer_tb: errors");
		end
		$finish;
	end

endmodule
